### src/rsic_pkg.sv
package rsic_pkg;

	localparam logic [31:0] PAD_WORD = 32'h3468_7195;
	localparam logic [31:0] WALK_STRIDE = 32'h0000_00d3;

	localparam logic [2:0] CMD_NOTE = 3'd0;
	localparam logic [2:0] CMD_CHECKED_WRITE = 3'd1;
	localparam logic [2:0] CMD_DIRTY_BUMP = 3'd2;
	localparam logic [2:0] CMD_COUNTER_CHECK = 3'd3;
	localparam logic [2:0] CMD_VERIFY_START = 3'd4;
	localparam logic [2:0] CMD_VERIFY_READ = 3'd5;

	localparam logic [1:0] KIND_ACK = 2'd0;
	localparam logic [1:0] KIND_WRITE_REQ = 2'd1;
	localparam logic [1:0] KIND_READ_REQ = 2'd2;
	localparam logic [1:0] KIND_FAULT = 2'd3;

	localparam logic [7:0] VIOL_WRITE_MISMATCH = 8'd2;

	localparam logic CFG_ERR_RESPONSE = 1'b0;
	localparam logic CFG_REFRESH_ADDR = 1'b1;

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b000_0000_0001,
		ST_SEARCH  = 11'b000_0000_0010,
		ST_RDWAIT  = 11'b000_0000_0100,
		ST_DECIDE  = 11'b000_0000_1000,
		ST_MODSUB  = 11'b000_0001_0000,
		ST_WALKRD  = 11'b000_0010_0000,
		ST_WALKCHK = 11'b000_0100_0000,
		ST_OUT1    = 11'b000_1000_0000,
		ST_OUT2    = 11'b001_0000_0000,
		ST_WALKADR = 11'b010_0000_0000,
		ST_HOLD    = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] bus_addr;
		logic [31:0] bus_data;
		logic [31:0] counter_value;
		logic [7:0]  fault_code;
		logic [31:0] alert_word;
		logic        table_full;
		logic        last;
	} result_t;

endpackage

### src/register_shadow_integrity_checker_unit.sv
// Register shadow integrity checker. Commands arrive as one beat on the
// in_valid/in_ready channel; results (one, or two for a verify start) leave
// on out_valid/out_ready, each through a single output register. The table
// lives in one memory pair (address, masked shadow), with one write port and
// one read port, that is searched linearly, entry by entry (read, then
// compare); a counter check or dirty bump answers straight from idle.
// A verify start searches, then reduces (seed + 0xd3) modulo the entry count
// with a shared compare-and-subtract unit, one quotient bit per cycle (count
// shifted left by 32 down to 0, 33 steps), then reads the first walk address.
// A walk read step compares the read value against the masked shadow; unless
// it is the last step of the walk or the compare fails, it then runs a 9-step
// reduction of index + stride and reads the next walk address. The input is
// not ready while an item is being worked or its results wait. After any
// fault the block stays halted and drops every command until reset.
// No clearing pass: data read from entries beyond the fill count is never used.
module register_shadow_integrity_checker_unit #(
	parameter int ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [31:0] reg_addr,
	input  logic [31:0] value,
	input  logic [31:0] read_value,
	input  logic [31:0] expected_count,
	input  logic [7:0]  violation,
	input  logic [31:0] random_seed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] bus_addr,
	output logic [31:0] bus_data,
	output logic [31:0] counter_value,
	output logic [7:0]  fault_code,
	output logic [31:0] alert_word,
	output logic        table_full,
	output logic        last
);
	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	// table memories
	logic [31:0] addr_mem [ENTRIES];
	logic [31:0] shad_mem [ENTRIES];
	logic [31:0] addr_rd_q, shad_rd_q;
	logic [IW-1:0] rd_idx;
	logic mem_we;
	logic [IW-1:0] wr_idx;
	logic [31:0] wr_addr, wr_shad;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			addr_mem[wr_idx] <= wr_addr;
			shad_mem[wr_idx] <= wr_shad;
		end
		addr_rd_q <= addr_mem[rd_idx];
		shad_rd_q <= shad_mem[rd_idx];
	end

	// control and state
	rsic_pkg::state_t state_q;
	logic [1:0]  err_resp_q;
	logic [31:0] refresh_q;
	logic [CW-1:0] count_q;
	logic [31:0] dirty_q, seq_q;
	logic [IW-1:0] walk_idx_q;
	logic [CW-1:0] walk_rem_q;
	logic halted_q;

	// item latch
	logic [2:0]  cmd_q;
	logic [31:0] addr_q, val_q, rd_q;
	logic [7:0]  viol_q;
	logic [CW-1:0] scan_q;       // search position
	logic found_q;
	logic [IW-1:0] hit_q;
	logic [32:0] rem_q;          // remainder under reduction
	logic [5:0]  shift_q;        // modulo step
	rsic_pkg::result_t res_q;
	logic out_valid_q;

	// shared compare-subtract for modulo: rem - (count << shift)
	logic [64:0] sub_op;
	logic [64:0] sub_diff;
	always_comb begin
		sub_op = 65'(count_q) << shift_q;
		sub_diff = {32'd0, rem_q} - sub_op;
	end

	assign in_ready = (state_q == rsic_pkg::ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign kind = res_q.kind;
	assign bus_addr = res_q.bus_addr;
	assign bus_data = res_q.bus_data;
	assign counter_value = res_q.counter_value;
	assign fault_code = res_q.fault_code;
	assign alert_word = res_q.alert_word;
	assign table_full = res_q.table_full;
	assign last = res_q.last;

	logic in_fire, out_fire;
	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;

	// the searched (or refresh) entry after search
	logic do_append;
	assign do_append = !found_q && (count_q < CW'(ENTRIES));

	// shadow update on a hit (not for checked write), or append
	logic dec_we;
	assign dec_we = (state_q == rsic_pkg::ST_DECIDE)
		&& ((found_q && cmd_q != rsic_pkg::CMD_CHECKED_WRITE) || do_append);

	always_comb begin
		rd_idx = scan_q[IW-1:0];
		if (state_q == rsic_pkg::ST_WALKADR || state_q == rsic_pkg::ST_WALKRD
			|| state_q == rsic_pkg::ST_WALKCHK || state_q == rsic_pkg::ST_OUT2
			|| state_q == rsic_pkg::ST_HOLD)
			rd_idx = walk_idx_q;
	end

	function automatic rsic_pkg::result_t mk(logic [1:0] k, logic [31:0] a,
		logic [31:0] d, logic [31:0] c, logic [7:0] f, logic [31:0] w,
		logic fl, logic l);
		rsic_pkg::result_t r;
		r.kind = k; r.bus_addr = a; r.bus_data = d; r.counter_value = c;
		r.fault_code = f; r.alert_word = w; r.table_full = fl; r.last = l;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		mem_we <= dec_we;
		if (dec_we) begin
			wr_idx <= found_q ? hit_q : count_q[IW-1:0];
			wr_addr <= addr_q;
			wr_shad <= rsic_pkg::PAD_WORD ^ val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsic_pkg::ST_IDLE;
			err_resp_q <= '0;
			refresh_q <= '0;
			count_q <= '0;
			dirty_q <= '0;
			seq_q <= '0;
			walk_idx_q <= '0;
			walk_rem_q <= '0;
			halted_q <= 1'b0;
			out_valid_q <= 1'b0;
			cmd_q <= '0; addr_q <= '0; val_q <= '0; rd_q <= '0;
			viol_q <= '0; scan_q <= '0; found_q <= 1'b0; hit_q <= '0;
			rem_q <= '0; shift_q <= '0;
			res_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == rsic_pkg::CFG_ERR_RESPONSE) err_resp_q <= cfg_wdata[1:0];
				else refresh_q <= cfg_wdata;
			end
			// HOLD reloads the output itself when the old beat leaves
			if (out_fire && state_q != rsic_pkg::ST_HOLD) out_valid_q <= 1'b0;
			case (state_q)
				rsic_pkg::ST_IDLE: begin
					if (in_fire && !halted_q) begin
						cmd_q <= cmd;
						addr_q <= (cmd == rsic_pkg::CMD_VERIFY_START) ? refresh_q : reg_addr;
						val_q <= (cmd == rsic_pkg::CMD_VERIFY_START) ? 32'd0 : value;
						rd_q <= read_value;
						viol_q <= violation;
						// walk start wraps at 32 bits
						rem_q <= {1'b0, random_seed + rsic_pkg::WALK_STRIDE};
						scan_q <= '0;
						found_q <= 1'b0;
						case (cmd)
							rsic_pkg::CMD_NOTE, rsic_pkg::CMD_CHECKED_WRITE,
							rsic_pkg::CMD_VERIFY_START: state_q <= rsic_pkg::ST_SEARCH;
							rsic_pkg::CMD_DIRTY_BUMP: begin
								dirty_q <= dirty_q + 32'd1;
								res_q <= mk(rsic_pkg::KIND_ACK, '0, '0, '0, '0, '0, 1'b0, 1'b1);
								out_valid_q <= 1'b1;
							end
							rsic_pkg::CMD_COUNTER_CHECK: begin
								if (seq_q != expected_count) begin
									halted_q <= 1'b1; walk_rem_q <= '0;
									res_q <= mk(rsic_pkg::KIND_FAULT, '0, '0, '0,
										{6'd0, err_resp_q} | violation,
										(seq_q << 16) | (expected_count << 4) | 32'd1,
										1'b0, 1'b1);
								end else if (dirty_q[0]) begin
									halted_q <= 1'b1; walk_rem_q <= '0;
									res_q <= mk(rsic_pkg::KIND_FAULT, '0, '0, '0,
										{6'd0, err_resp_q} | violation,
										(dirty_q << 16) | 32'd2, 1'b0, 1'b1);
								end else begin
									seq_q <= seq_q + 32'd1;
									res_q <= mk(rsic_pkg::KIND_ACK, '0, '0, seq_q + 32'd1,
										'0, '0, 1'b0, 1'b1);
								end
								out_valid_q <= 1'b1;
							end
							rsic_pkg::CMD_VERIFY_READ: begin
								if (walk_rem_q != '0 && count_q != '0)
									state_q <= rsic_pkg::ST_WALKRD;
							end
							default: ;
						endcase
					end
				end
				rsic_pkg::ST_SEARCH: begin
					// memory read issued at scan_q, data next cycle
					if (scan_q >= count_q || found_q) state_q <= rsic_pkg::ST_DECIDE;
					else state_q <= rsic_pkg::ST_RDWAIT;
				end
				rsic_pkg::ST_RDWAIT: begin
					if (addr_rd_q == addr_q) begin
						found_q <= 1'b1;
						hit_q <= scan_q[IW-1:0];
						state_q <= rsic_pkg::ST_OUT1;
					end else begin
						scan_q <= scan_q + CW'(1);
						state_q <= rsic_pkg::ST_SEARCH;
					end
				end
				rsic_pkg::ST_OUT1: begin
					// wait for shadow of hit (read at hit index)
					state_q <= rsic_pkg::ST_DECIDE;
				end
				rsic_pkg::ST_DECIDE: begin
					if (!found_q && do_append) count_q <= count_q + CW'(1);
					case (cmd_q)
						rsic_pkg::CMD_NOTE: begin
							dirty_q <= dirty_q + 32'd1;
							res_q <= mk(rsic_pkg::KIND_ACK, '0, '0, '0, '0, '0,
								!found_q && !do_append, 1'b1);
							out_valid_q <= 1'b1;
							state_q <= rsic_pkg::ST_IDLE;
						end
						rsic_pkg::CMD_CHECKED_WRITE: begin
							if (found_q) begin
								if ((rd_q ^ rsic_pkg::PAD_WORD) != shad_rd_q || rd_q != val_q) begin
									halted_q <= 1'b1; walk_rem_q <= '0;
									res_q <= mk(rsic_pkg::KIND_FAULT, '0, '0, '0,
										{6'd0, err_resp_q} | rsic_pkg::VIOL_WRITE_MISMATCH,
										addr_q, 1'b0, 1'b1);
								end else
									res_q <= mk(rsic_pkg::KIND_ACK, '0, val_q, '0, '0, '0,
										1'b0, 1'b1);
							end else
								res_q <= mk(rsic_pkg::KIND_WRITE_REQ, addr_q, val_q, '0, '0,
									'0, !do_append, 1'b1);
							out_valid_q <= 1'b1;
							state_q <= rsic_pkg::ST_IDLE;
						end
						default: begin
							// verify start: dirty +2
							dirty_q <= dirty_q + 32'd2;
							res_q <= mk(rsic_pkg::KIND_WRITE_REQ, addr_q, '0, '0, '0, '0,
								!found_q && !do_append, 1'b0);
							out_valid_q <= 1'b1;
							shift_q <= 6'd32;
							state_q <= rsic_pkg::ST_MODSUB;
						end
					endcase
				end
				rsic_pkg::ST_MODSUB: begin
					// restoring reduction of rem_q modulo count_q
					if (!sub_diff[64]) rem_q <= sub_diff[32:0];
					if (shift_q == 6'd0) begin
						state_q <= rsic_pkg::ST_WALKADR;
					end else
						shift_q <= shift_q - 6'd1;
					// walk length is set only when a walk starts
					if (cmd_q == rsic_pkg::CMD_VERIFY_START) walk_rem_q <= count_q;
				end
				rsic_pkg::ST_WALKADR: begin
					walk_idx_q <= rem_q[IW-1:0];
					state_q <= rsic_pkg::ST_OUT2;
				end
				rsic_pkg::ST_OUT2: begin
					// rd_idx = walk_idx_q now valid; data arrives next cycle
					state_q <= rsic_pkg::ST_HOLD;
				end
				rsic_pkg::ST_HOLD: begin
					if (!out_valid_q || out_fire) begin
						res_q <= mk(rsic_pkg::KIND_READ_REQ, addr_rd_q, '0, '0, '0, '0,
							1'b0, 1'b1);
						out_valid_q <= 1'b1;
						state_q <= rsic_pkg::ST_IDLE;
					end
				end
				rsic_pkg::ST_WALKRD: begin
					state_q <= rsic_pkg::ST_WALKCHK;
				end
				rsic_pkg::ST_WALKCHK: begin
					if ((rd_q ^ rsic_pkg::PAD_WORD) != shad_rd_q) begin
						halted_q <= 1'b1; walk_rem_q <= '0;
						res_q <= mk(rsic_pkg::KIND_FAULT, '0, '0, '0,
							{6'd0, err_resp_q} | viol_q, addr_rd_q, 1'b0, 1'b1);
						out_valid_q <= 1'b1;
						state_q <= rsic_pkg::ST_IDLE;
					end else if (walk_rem_q == CW'(1)) begin
						walk_rem_q <= '0;
						seq_q <= seq_q + 32'd1;
						res_q <= mk(rsic_pkg::KIND_ACK, '0, '0, seq_q + 32'd1, '0, '0,
							1'b0, 1'b1);
						out_valid_q <= 1'b1;
						state_q <= rsic_pkg::ST_IDLE;
					end else begin
						walk_rem_q <= walk_rem_q - CW'(1);
						// index + stride, then reduce (sum < count + 211 < 2^33)
						rem_q <= 33'(walk_idx_q) + {1'b0, rsic_pkg::WALK_STRIDE};
						shift_q <= 6'd8;
						state_q <= rsic_pkg::ST_MODSUB;
					end
				end
				default: state_q <= rsic_pkg::ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == rsic_pkg::ST_IDLE)
		else $error("ready outside idle");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halted_q) |-> halted_q)
		else $error("halt cleared");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("count overflow");
	a_fault_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == rsic_pkg::KIND_FAULT |-> res_q.last)
		else $error("fault not last");
`endif

endmodule
